// ----- rtl/core/lpfr_pkg.sv -----
// Package with the shared types and constants of the length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LENGTH_W   = 16;
    localparam int HDR_IDX_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Header byte positions; the marker position doubles as the hunting state.
    localparam logic [HDR_IDX_W-1:0] HDR_MARKER = 2'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_SPARE  = 2'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO = 2'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LENGTH = 2'd1;

    localparam logic [BYTE_W-1:0]   START_MARKER_RESET    = 8'h00;
    localparam logic [LENGTH_W-1:0] MAX_BODY_LENGTH_RESET = 16'hFFFF;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] body_byte;
        logic              is_last;
    } lpfr_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/length_prefixed_frame_receiver.sv -----
// Top level of the length-prefixed frame receiver.
//
//  Channel  Direction  Handshake                      Payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata[7:0] data_byte
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata[7:0] body_byte, tlast is_last
//  cfg      in         cfg_valid / cfg_ready          cfg_index, cfg_data[15:0]
//
// One item is taken per cycle unless a body byte waits in the input register;
// each body byte goes from the input register through the header and body
// logic into the result register, which drives m_axis. Header bytes give no result and
// never wait for the output. A body byte waits in the input register only while
// the result register is full and not being taken. Reset clears all control
// state and sets the marker to zero and the maximum body length to 65535.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver
    import lpfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [BYTE_W-1:0]          m_axis_tdata,   // [7:0] body_byte
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic                in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]   in_data_reg;
    logic [BYTE_W-1:0]   start_marker_reg;
    logic [LENGTH_W-1:0] max_body_length_reg;
    lpfr_result_t        result;
    logic                out_free;
    logic                advance;
    logic                in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg    <= START_MARKER_RESET;
            max_body_length_reg <= MAX_BODY_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_MARKER:    start_marker_reg    <= cfg_data[BYTE_W-1:0];
                CFG_MAX_BODY_LENGTH: max_body_length_reg <= cfg_data[LENGTH_W-1:0];
                default:             ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!result.valid || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    lpfr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .data_byte       (in_data_reg),
        .start_marker    (start_marker_reg),
        .max_body_length (max_body_length_reg),
        .result          (result)
    );

    lpfr_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && result.valid),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lpfr_parser.sv -----
// Header and body tracking state of the length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_parser
    import lpfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic [BYTE_W-1:0]   start_marker,
    input  wire logic [LENGTH_W-1:0] max_body_length,
    output lpfr_result_t             result
);

    logic [HDR_IDX_W-1:0] header_index_reg, header_index_next;
    logic                 in_body_reg, in_body_next;
    logic [BYTE_W-1:0]    length_low_reg, length_low_next;
    logic [LENGTH_W-1:0]  body_length_reg, body_length_next;
    logic [LENGTH_W-1:0]  body_count_reg, body_count_next;
    logic [LENGTH_W-1:0]  count_inc;
    logic [LENGTH_W-1:0]  header_length;
    logic                 last_byte;

    assign count_inc     = body_count_reg + LENGTH_W'(1);
    assign last_byte     = (count_inc == body_length_reg);
    assign header_length = {data_byte, length_low_reg};

    assign result.valid     = in_body_reg;
    assign result.body_byte = data_byte;
    assign result.is_last   = last_byte;

    always_comb
    begin
        header_index_next = header_index_reg;
        in_body_next      = in_body_reg;
        length_low_next   = length_low_reg;
        body_length_next  = body_length_reg;
        body_count_next   = body_count_reg;
        if (step)
        begin
            if (in_body_reg)
            begin
                if (last_byte)
                begin
                    in_body_next      = 1'b0;
                    body_count_next   = '0;
                    header_index_next = HDR_MARKER;
                end
                else
                begin
                    body_count_next = count_inc;
                end
            end
            else
            begin
                case (header_index_reg)
                    HDR_MARKER:
                    begin
                        if (data_byte == start_marker)
                        begin
                            header_index_next = HDR_SPARE;
                        end
                    end
                    HDR_SPARE:
                    begin
                        header_index_next = HDR_LEN_LO;
                    end
                    HDR_LEN_LO:
                    begin
                        length_low_next   = data_byte;
                        header_index_next = HDR_LEN_HI;
                    end
                    default:
                    begin
                        header_index_next = HDR_MARKER;
                        if ((header_length != '0) && (header_length <= max_body_length))
                        begin
                            body_length_next = header_length;
                            body_count_next  = '0;
                            in_body_next     = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= HDR_MARKER;
            in_body_reg      <= 1'b0;
            length_low_reg   <= '0;
            body_length_reg  <= '0;
            body_count_reg   <= '0;
        end
        else
        begin
            header_index_reg <= header_index_next;
            in_body_reg      <= in_body_next;
            length_low_reg   <= length_low_next;
            body_length_reg  <= body_length_next;
            body_count_reg   <= body_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lpfr_out_stage.sv -----
// Result register of the length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_out_stage
    import lpfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire lpfr_result_t      result,
    output logic                   free,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.body_byte;
            last_reg <= result.is_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire
